@@ rtl/hdm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdm_pkg: shared types, constants and helpers for the heading table match
// Word formats of the request and response channels, register codes and
// reset values, and the per-axis tolerance test.
// ----------------------------------------------------------------------------
package hdm_pkg;

   // field widths of the channel words
   localparam int READING_BITS = 16;
   localparam int SLOT_W       = 12;
   localparam int TOL_W        = 16;
   localparam int USED_W       = 13;
   localparam int HEAD_W       = 12;
   localparam int COUNT_W      = 13;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOL_X        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_Y        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_Z        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_USED = 2'd3;

   localparam logic [TOL_W-1:0]  TOL_X_RST        = 16'd600;
   localparam logic [TOL_W-1:0]  TOL_Y_RST        = 16'd600;
   localparam logic [TOL_W-1:0]  TOL_Z_RST        = 16'd0;
   localparam logic [USED_W-1:0] ENTRIES_USED_RST = 13'd3600;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // default table size
   localparam int TABLE_DEPTH_DEF = 4096;

   // one table entry: three axes
   localparam int WORD_W = 3 * READING_BITS;

   typedef struct packed {
      logic                           mode;
      logic [SLOT_W-1:0]              entry_index;
      logic signed [READING_BITS-1:0] reading_x;
      logic signed [READING_BITS-1:0] reading_y;
      logic signed [READING_BITS-1:0] reading_z;
   } hdm_req_type;

   typedef struct packed {
      logic               found;
      logic [HEAD_W-1:0]  heading_tenths;
      logic [COUNT_W-1:0] match_count;
   } hdm_rsp_type;

   // |query - entry| < tol, strict
   function automatic logic axis_hit(input logic signed [READING_BITS-1:0] query,
                                     input logic signed [READING_BITS-1:0] entry,
                                     input logic [TOL_W-1:0]               tol);
      logic signed [READING_BITS:0] diff;
      logic [READING_BITS:0]        mag;
      diff = {query[READING_BITS-1], query} - {entry[READING_BITS-1], entry};
      mag  = diff[READING_BITS] ? (READING_BITS+1)'(-diff) : diff;
      return 33'(mag) < 33'(tol);
   endfunction

   // at least two of three
   function automatic logic two_of_three(input logic a, input logic b, input logic c);
      return (a & b) | (a & c) | (b & c);
   endfunction

endpackage
`default_nettype wire

@@ rtl/hdm_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdm_table: reference reading table
// Single-port-write, single-port-read synchronous memory holding the three
// axes of each heading step in one word; read data is registered.
// ----------------------------------------------------------------------------
module hdm_table #(
   parameter int  TABLE_DEPTH = hdm_pkg::TABLE_DEPTH_DEF,
   localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [hdm_pkg::WORD_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output      logic [hdm_pkg::WORD_W-1:0] rd_data
);

   logic [hdm_pkg::WORD_W-1:0] mem_ff [TABLE_DEPTH];
   logic [hdm_pkg::WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/hdm_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdm_divider: serial unsigned divider
// Restoring division, one quotient bit per cycle; computes the mean index
// from the index sum and the match count.
// ----------------------------------------------------------------------------
module hdm_divider #(
   parameter int  SUM_W = 24,
   parameter int  CNT_W = 13,
   localparam int STEP_W = $clog2(SUM_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output      logic             done,
   output      logic [SUM_W-1:0] quotient
);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   logic [CNT_W-1:0]  rem_ff,   rem_in;
   logic [SUM_W-1:0]  quo_ff,   quo_in;
   logic [CNT_W-1:0]  dvs_ff,   dvs_in;

   logic [CNT_W:0] shifted;
   logic [CNT_W:0] trial;
   logic           fits;

   // one restoring step: dividend bits enter from the top of quo_ff
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/heading_table_match_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// heading_table_match_unit: magnetometer heading lookup by table match
// A request word either loads one table entry (mode 0) or runs a heading
// query (mode 1). A query yields one response word; a load yields none.
//
// Usage:
//   - csr_*: register writes (tolerances, entries scanned), taken at any
//     time with csr_ready high; write only while the unit is idle.
//   - req_*: one word at a time. A load is written into the table in the
//     cycle it is accepted and the next word can follow at once.
//   - A query scans entries 0..N-1 (N = min(entries_used, TABLE_DEPTH)),
//     one table read per cycle through a three-stage read/compare/sum
//     pipeline; when more than one entry matched, a serial divider then
//     forms the mean index. From the accepting edge req_stall is high
//     until rsp_valid rises.
//   - rsp_*: the result sits in an output register; if rsp_stall holds it,
//     the unit still accepts the next request word, and a following query
//     waits at its end until the register is free.
//   - Reset restores the register defaults and empties the pipeline; the
//     table content is undefined until loaded.
// ----------------------------------------------------------------------------
module heading_table_match_unit #(
   parameter int TABLE_DEPTH = hdm_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire hdm_pkg::hdm_req_type              req_data,
   // response channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      hdm_pkg::hdm_rsp_type              rsp_data,
   // register write channel
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [hdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hdm_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W  = 2 * ADDR_W;
   localparam int RB     = hdm_pkg::READING_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type                    state_ff,   state_in;
   logic [hdm_pkg::TOL_W-1:0]    tol_x_ff,   tol_y_ff,  tol_z_ff;
   logic [hdm_pkg::USED_W-1:0]   used_ff;
   logic signed [RB-1:0]         qx_ff,      qx_in;
   logic signed [RB-1:0]         qy_ff,      qy_in;
   logic signed [RB-1:0]         qz_ff,      qz_in;
   logic [CNT_W-1:0]             addr_ff,    addr_in;
   logic [CNT_W-1:0]             limit_ff,   limit_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]            rd_idx_ff,  rd_idx_in;
   logic                         hit_ff,     hit_in;
   logic [ADDR_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]             count_ff,   count_in;
   logic [SUM_W-1:0]             sum_ff,     sum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hdm_pkg::hdm_rsp_type         rsp_data_ff,  rsp_data_in;

   // ---------------------------------------------------------------- wires
   logic                   req_take;
   logic                   load_wr;
   logic                   rd_issue;
   logic                   rsp_load;
   logic                   div_start;
   logic                   div_done;
   logic [SUM_W-1:0]       div_quo;
   logic [hdm_pkg::WORD_W-1:0] rd_word;
   logic signed [RB-1:0]   ex, ey, ez;
   logic                   match;
   logic                   drained;
   logic                   found;
   logic [31:0]            used_32;
   logic [31:0]            limit_32;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_wr   = req_take && (req_data.mode == hdm_pkg::MODE_LOAD)
                      && (32'(req_data.entry_index) < 32'(TABLE_DEPTH));
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- table
   hdm_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (ADDR_W'(req_data.entry_index)),
      .wr_data ({req_data.reading_x, req_data.reading_y, req_data.reading_z}),
      .rd_en   (rd_issue),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_word)
   );

   // ---------------------------------------------------------------- divider
   hdm_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // scan length, saturated at the table depth
   assign used_32  = 32'(used_ff);
   assign limit_32 = (used_32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : used_32;

   // compare stage on the registered table word
   assign ex    = rd_word[3*RB-1:2*RB];
   assign ey    = rd_word[2*RB-1:RB];
   assign ez    = rd_word[RB-1:0];
   assign match = hdm_pkg::two_of_three(hdm_pkg::axis_hit(qx_ff, ex, tol_x_ff),
                                        hdm_pkg::axis_hit(qy_ff, ey, tol_y_ff),
                                        hdm_pkg::axis_hit(qz_ff, ez, tol_z_ff));

   assign rd_issue = (state_ff == ST_SCAN) && (addr_ff != limit_ff);
   assign drained  = (addr_ff == limit_ff) && !rd_valid_ff && !hit_ff;
   assign found    = (count_ff > CNT_W'(1));
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign div_start = (state_ff == ST_SCAN) && drained && found;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      addr_in      = addr_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // read pipeline
      rd_valid_in = rd_issue;
      rd_idx_in   = addr_ff[ADDR_W-1:0];
      hit_in      = rd_valid_ff && match;
      hit_idx_in  = rd_idx_ff;

      // output register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.mode == hdm_pkg::MODE_QUERY)) begin
               qx_in    = req_data.reading_x;
               qy_in    = req_data.reading_y;
               qz_in    = req_data.reading_z;
               addr_in  = '0;
               limit_in = CNT_W'(limit_32);
               count_in = '0;
               sum_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (hit_ff) begin
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + SUM_W'(hit_idx_ff);
            end
            if (drained) begin
               state_in = found ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.found          = found;
               rsp_data_in.heading_tenths = found ? hdm_pkg::HEAD_W'(div_quo) : '0;
               rsp_data_in.match_count    = hdm_pkg::COUNT_W'(count_ff);
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, pipeline and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      addr_ff     <= addr_in;
      limit_ff    <= limit_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      count_ff    <= count_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_x_ff <= hdm_pkg::TOL_X_RST;
         tol_y_ff <= hdm_pkg::TOL_Y_RST;
         tol_z_ff <= hdm_pkg::TOL_Z_RST;
         used_ff  <= hdm_pkg::ENTRIES_USED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hdm_pkg::CSR_TOL_X:        tol_x_ff <= csr_data;
            hdm_pkg::CSR_TOL_Y:        tol_y_ff <= csr_data;
            hdm_pkg::CSR_TOL_Z:        tol_z_ff <= csr_data;
            hdm_pkg::CSR_ENTRIES_USED: used_ff  <= hdm_pkg::USED_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // scan address never runs past the scan length
   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff <= limit_ff))
      else $error("scan address beyond scan length");

   // matches never outnumber the entries read so far
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff <= addr_ff))
      else $error("match count exceeds entries read");

   // the divider only finishes while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide phase");

   // a new result never overwrites one the receiver still holds
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("held response was overwritten");

   // the table is never read while a load writes it
   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      load_wr |-> !rd_issue)
      else $error("table read during load");

endmodule
`default_nettype wire

@@ dv/heading_table_match_unit_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// heading_table_match_unit_test: self-checking bench for the heading matcher
// Loads magnetometer table entries and runs heading queries through the
// request channel. A local model of the table, the tolerances and the
// entry count predicts every response word, and the monitor compares them
// field by field. Register settings change between phases while the unit
// is idle. Random idle bursts are applied on both channels.
// ----------------------------------------------------------------------------
module heading_table_match_unit_test;

   localparam int DEPTH         = hdm_pkg::TABLE_DEPTH_DEF;
   // slowest pass: ~160 words, each behind a random idle gap, a scan of up to
   // 64 entries, the divider and a response stall; the limit covers that
   // pass several times over
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_MAX    = 10;
   localparam int FINAL_USED    = 64;

   typedef struct {
      hdm_pkg::hdm_req_type word;
      bit                   drain;   // hold this word until every response is back
   } backlog_entry_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   hdm_pkg::hdm_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   hdm_pkg::hdm_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [hdm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [hdm_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   heading_table_match_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and scoreboard state
   backlog_entry_type    word_backlog [$];
   hdm_pkg::hdm_rsp_type heading_due [$];
   int                   idle_odds = 4;   // 0 turns idling off on both sides
   bit                   req_fired = 1'b0;

   // generator view of which slots hold data
   bit slot_loaded [DEPTH];
   int loaded_prefix = 0;

   // local model of the unit
   logic signed [hdm_pkg::READING_BITS-1:0] tab_x [DEPTH];
   logic signed [hdm_pkg::READING_BITS-1:0] tab_y [DEPTH];
   logic signed [hdm_pkg::READING_BITS-1:0] tab_z [DEPTH];
   logic [hdm_pkg::TOL_W-1:0]  cfg_tol_x;
   logic [hdm_pkg::TOL_W-1:0]  cfg_tol_y;
   logic [hdm_pkg::TOL_W-1:0]  cfg_tol_z;
   logic [hdm_pkg::USED_W-1:0] cfg_used;

   int mismatches  = 0;
   int cycle_count = 0;
   int n_loads     = 0;
   int n_queries   = 0;
   int n_results   = 0;
   int n_found     = 0;

   // strict per-axis window: |q - e| < tol
   function automatic bit within_tol(input logic signed [hdm_pkg::READING_BITS-1:0] q,
                                     input logic signed [hdm_pkg::READING_BITS-1:0] e,
                                     input logic [hdm_pkg::TOL_W-1:0] tol);
      int d;
      d = int'(q) - int'(e);
      if (d < 0) d = -d;
      return d < int'({16'd0, tol});
   endfunction

   // scan the used entries, two of three axes must hit
   function automatic hdm_pkg::hdm_rsp_type heading_for(input hdm_pkg::hdm_req_type w);
      hdm_pkg::hdm_rsp_type r;
      int          span;
      int          hits;
      int          count;
      longint      total;
      span  = (int'(cfg_used) > DEPTH) ? DEPTH : int'(cfg_used);
      count = 0;
      total = 0;
      for (int i = 0; i < span; i++) begin
         hits = int'(within_tol(w.reading_x, tab_x[i], cfg_tol_x))
              + int'(within_tol(w.reading_y, tab_y[i], cfg_tol_y))
              + int'(within_tol(w.reading_z, tab_z[i], cfg_tol_z));
         if (hits >= 2) begin
            count++;
            total += i;
         end
      end
      r.found          = (count > 1);
      r.heading_tenths = (count > 1) ? hdm_pkg::HEAD_W'(total / count) : '0;
      r.match_count    = hdm_pkg::COUNT_W'(count);
      return r;
   endfunction

   // request driver: changes on the falling edge
   always @(negedge clock) begin
      logic hold;
      int   gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         hold = req_valid;
         if (req_valid && req_fired) begin
            void'(word_backlog.pop_front());
            hold = 1'b0;
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_backlog.size() != 0 &&
                         !(word_backlog[0].drain && heading_due.size() != 0)) begin
               if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                  gap_left = $urandom_range(1, 13) - 1;
               end else begin
                  hold = 1'b1;
                  req_data <= word_backlog[0].word;
               end
            end
         end
         req_valid <= hold;
      end
   end

   // response back-pressure in bursts
   always @(negedge clock) begin
      int stall_left;
      if (reset || idle_odds == 0) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: sample on the rising edge, predict and check
   always @(posedge clock) begin
      hdm_pkg::hdm_rsp_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, heading_due.size());
         $display("heading_table_match_unit_test: FAIL");
         $finish;
      end
      if (reset) begin
         req_fired = 1'b0;
         cfg_tol_x = hdm_pkg::TOL_X_RST;
         cfg_tol_y = hdm_pkg::TOL_Y_RST;
         cfg_tol_z = hdm_pkg::TOL_Z_RST;
         cfg_used  = hdm_pkg::ENTRIES_USED_RST;
      end else begin
         req_fired = req_valid && !req_stall;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               hdm_pkg::CSR_TOL_X:        cfg_tol_x = csr_data;
               hdm_pkg::CSR_TOL_Y:        cfg_tol_y = csr_data;
               hdm_pkg::CSR_TOL_Z:        cfg_tol_z = csr_data;
               hdm_pkg::CSR_ENTRIES_USED: cfg_used  = csr_data[hdm_pkg::USED_W-1:0];
               default: ;
            endcase
         end

         // response word
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (rsp_data.found) n_found++;
            if (heading_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("cycle %0d: unexpected response found=%0d heading=%0d count=%0d",
                           cycle_count, rsp_data.found, rsp_data.heading_tenths,
                           rsp_data.match_count);
            end else begin
               want = heading_due.pop_front();
               if (rsp_data.found !== want.found ||
                   rsp_data.heading_tenths !== want.heading_tenths ||
                   rsp_data.match_count !== want.match_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"cycle %0d: expected found=%0d heading=%0d count=%0d,",
                               " got found=%0d heading=%0d count=%0d"},
                              cycle_count, want.found, want.heading_tenths,
                              want.match_count, rsp_data.found,
                              rsp_data.heading_tenths, rsp_data.match_count);
               end
            end
         end

         // request word: loads update the table, queries queue a prediction
         if (req_fired) begin
            if (req_data.mode == hdm_pkg::MODE_LOAD) begin
               n_loads++;
               tab_x[req_data.entry_index] = req_data.reading_x;
               tab_y[req_data.entry_index] = req_data.reading_y;
               tab_z[req_data.entry_index] = req_data.reading_z;
            end else begin
               n_queries++;
               heading_due = {heading_due, heading_for(req_data)};
            end
         end
      end
   end

   // ---- stimulus helpers ----

   task automatic post_load(input int slot, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      backlog_entry_type b;
      b.word.mode        = hdm_pkg::MODE_LOAD;
      b.word.entry_index = hdm_pkg::SLOT_W'(slot);
      b.word.reading_x   = x;
      b.word.reading_y   = y;
      b.word.reading_z   = z;
      b.drain            = 1'b0;
      word_backlog = {word_backlog, b};
      slot_loaded[slot] = 1'b1;
      while (loaded_prefix < DEPTH && slot_loaded[loaded_prefix]) loaded_prefix++;
   endtask

   // entry_index carries junk on queries; the unit must ignore it
   task automatic post_query(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input bit drain);
      backlog_entry_type b;
      b.word.mode        = hdm_pkg::MODE_QUERY;
      b.word.entry_index = hdm_pkg::SLOT_W'($urandom);
      b.word.reading_x   = x;
      b.word.reading_y   = y;
      b.word.reading_z   = z;
      b.drain            = drain;
      word_backlog = {word_backlog, b};
   endtask

   // register write while the unit is idle
   task automatic write_csr(input logic [hdm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hdm_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all words taken, all responses back, pipeline drained
   task automatic settle();
      do @(negedge clock);
      while (word_backlog.size() != 0 || req_valid || heading_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // reading near a cluster center, occasionally an extreme or pure noise
   function automatic logic [15:0] sample_axis(input logic [15:0] c, input int spread,
                                               input bit noise);
      int pick;
      pick = $urandom_range(0, 31);
      if (noise) return 16'($urandom);
      if (pick == 0) return 16'h8000;
      if (pick == 1) return 16'h7fff;
      return 16'(int'($signed(c)) + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic logic [hdm_pkg::TOL_W-1:0] pick_tol();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return hdm_pkg::TOL_W'($urandom_range(0, 2500));
   endfunction

   // ---- test sequence ----
   initial begin
      logic [15:0] cx, cy, cz;
      int          spread;
      int          n;
      int          slot;
      bit          noise;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset tolerances, eight hand-picked entries plus the top slot
      write_csr(hdm_pkg::CSR_ENTRIES_USED, 16'd8);
      post_load(0, 0, 0, 0);
      post_load(1, 100, 100, 100);
      post_load(2, 200, -200, 0);
      post_load(3, 32767, 32767, 32767);
      post_load(4, -32768, -32768, -32768);
      post_load(5, 50, 50, -50);
      post_load(6, -1, -1, -1);
      post_load(7, 32767, -32768, 0);
      post_load(DEPTH - 1, 1234, -1234, 77);
      post_query(0, 0, 0, 1'b0);                  // several matches
      post_query(32767, 32767, 32767, 1'b1);      // single match, sender waits first
      post_query(-32768, -32768, -32768, 1'b0);   // single match at the low end
      post_query(600, 0, 0, 1'b0);                // distance equal to tolerance
      post_query(-32768, 32767, 0, 1'b0);         // no match
      post_query(32767, -32768, -5, 1'b0);
      settle();

      // widest tolerance on x and z, y can never hit
      write_csr(hdm_pkg::CSR_TOL_X, 16'hffff);
      write_csr(hdm_pkg::CSR_TOL_Y, 16'h0000);
      write_csr(hdm_pkg::CSR_TOL_Z, 16'hffff);
      post_query(32767, 0, 32767, 1'b0);
      post_query(-32768, 0, -32768, 1'b0);
      settle();

      // all tolerances zero: nothing matches
      write_csr(hdm_pkg::CSR_TOL_X, 16'h0000);
      write_csr(hdm_pkg::CSR_TOL_Z, 16'h0000);
      post_query(0, 0, 0, 1'b0);
      settle();

      // empty scan, then a one-entry scan
      write_csr(hdm_pkg::CSR_ENTRIES_USED, 16'd0);
      post_query(0, 0, 0, 1'b0);
      settle();
      write_csr(hdm_pkg::CSR_ENTRIES_USED, 16'd1);
      write_csr(hdm_pkg::CSR_TOL_X, 16'd600);
      write_csr(hdm_pkg::CSR_TOL_Y, 16'd600);
      post_query(5, 5, 5, 1'b0);
      settle();

      // random phases over small tables
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(hdm_pkg::CSR_TOL_X, pick_tol());
         write_csr(hdm_pkg::CSR_TOL_Y, pick_tol());
         write_csr(hdm_pkg::CSR_TOL_Z, pick_tol());
         n = (ph == 0) ? 1 : (ph == 1) ? 2 : $urandom_range(3, 48);
         // upper data bits lie beyond the register and must be dropped
         write_csr(hdm_pkg::CSR_ENTRIES_USED, {3'($urandom), 13'(n)});
         case ($urandom_range(0, 2))
            0:       idle_odds <= 0;
            1:       idle_odds <= 3;
            default: idle_odds <= 8;
         endcase
         cx = 16'($urandom);
         cy = 16'($urandom);
         cz = 16'($urandom);
         spread = $urandom_range(0, 1500);

         while (loaded_prefix < n)
            post_load(loaded_prefix, sample_axis(cx, spread, 1'b0),
                      sample_axis(cy, spread, 1'b0), sample_axis(cz, spread, 1'b0));

         for (int k = 0; k < 10; k++) begin
            noise = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 5) begin
               post_query(sample_axis(cx, spread, noise), sample_axis(cy, spread, noise),
                          sample_axis(cz, spread, noise), $urandom_range(0, 7) == 0);
            end else begin
               slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH - 1)
                                                  : $urandom_range(0, n + 7);
               post_load(slot, sample_axis(cx, spread, noise),
                         sample_axis(cy, spread, noise), sample_axis(cz, spread, noise));
            end
         end
         settle();
      end

      // last part: no idling, a wider filled prefix, then all windows wide open
      idle_odds <= 0;
      write_csr(hdm_pkg::CSR_TOL_X, 16'd600);
      write_csr(hdm_pkg::CSR_TOL_Y, 16'd600);
      write_csr(hdm_pkg::CSR_TOL_Z, 16'd600);
      write_csr(hdm_pkg::CSR_ENTRIES_USED, 16'(FINAL_USED));
      cx = 16'($urandom);
      cy = 16'($urandom);
      cz = 16'($urandom);
      spread = 2000;
      while (loaded_prefix < FINAL_USED)
         post_load(loaded_prefix, sample_axis(cx, spread, 1'b0),
                   sample_axis(cy, spread, 1'b0), sample_axis(cz, spread, 1'b0));
      post_query(cx, cy, cz, 1'b0);
      post_query(sample_axis(cx, spread, 1'b0), sample_axis(cy, spread, 1'b0),
                 sample_axis(cz, spread, 1'b0), 1'b0);
      post_query(sample_axis(cx, spread, 1'b0), sample_axis(cy, spread, 1'b0),
                 sample_axis(cz, spread, 1'b0), 1'b0);
      settle();
      write_csr(hdm_pkg::CSR_TOL_X, 16'hffff);
      write_csr(hdm_pkg::CSR_TOL_Y, 16'hffff);
      write_csr(hdm_pkg::CSR_TOL_Z, 16'hffff);
      post_query(cx, cy, cz, 1'b0);     // nearly every entry matches
      settle();

      mismatches += heading_due.size();
      $display("ran %0d table loads and %0d heading queries over %0d cycles",
               n_loads, n_queries, cycle_count);
      $display("checked %0d response words, %0d with a heading found; %0d errors",
               n_results, n_found, mismatches);
      if (mismatches == 0)
         $display("heading_table_match_unit_test: PASS");
      else
         $display("heading_table_match_unit_test: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/hdm_pkg.sv
rtl/hdm_table.sv
rtl/hdm_divider.sv
rtl/heading_table_match_unit.sv
dv/heading_table_match_unit_test.sv
